// File: design/rwmc_pkg.sv
// Shared constants, types and helper functions of the maze carver.
`default_nettype none

package rwmc_pkg;

	// map geometry
	localparam int CELLS_PER_SIDE = 32;
	localparam int CELL_W         = $clog2(CELLS_PER_SIDE);
	localparam int ADDR_W         = 2 * CELL_W;
	localparam int MAP_DEPTH      = CELLS_PER_SIDE * CELLS_PER_SIDE;

	// field widths
	localparam int COORD_W = 7;
	localparam int CNT_W   = 11;
	localparam int TOTAL_W = 2 * (COORD_W - 1);
	localparam int EPOCH_W = 8;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	localparam logic [COORD_W-1:0] GRID_MIN   = COORD_W'(3);
	localparam logic [COORD_W-1:0] GRID_LIM   = COORD_W'(2 * CELLS_PER_SIDE + 1);
	localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

	// item kinds (tuser)
	localparam logic FUNC_BEGIN = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// direction codes
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// result status codes
	localparam logic [1:0] ST_WALK   = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_IDLE   = 2'd3;

	// configuration register indexes
	localparam logic CFG_GRID_WIDTH  = 1'b0;
	localparam logic CFG_GRID_HEIGHT = 1'b1;

	// what the first stage decided for an item
	localparam logic [2:0] OP_BEGIN  = 3'd0;  // start cell accepted
	localparam logic [2:0] OP_REJECT = 3'd1;  // bad geometry or start
	localparam logic [2:0] OP_IDLE   = 3'd2;  // step with no maze
	localparam logic [2:0] OP_FIN    = 3'd3;  // step after the walk is done
	localparam logic [2:0] OP_MOVE   = 3'd4;  // walker moved, carve if unvisited
	localparam logic [2:0] OP_STAY   = 3'd5;  // no direction leads inside

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic                ok;
		coord_t              width;
		coord_t              height;
		logic [TOTAL_W-1:0]  total;
	} geo_t;

	typedef struct packed {
		logic [2:0]          op;
		coord_t              cur_x;
		coord_t              cur_y;
		coord_t              wall_x;
		coord_t              wall_y;
		logic [ADDR_W-1:0]   addr;
		logic [EPOCH_W-1:0]  epoch;
	} s1_item_t;

	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [EPOCH_W-1:0]  mark;
	} item_wr_t;

	typedef struct packed {
		logic                start;
		logic [ADDR_W-1:0]   idx;
		logic [EPOCH_W-1:0]  epoch;
	} clr_req_t;

	typedef struct packed {
		coord_t              cur_x;
		coord_t              cur_y;
		logic                carved;
		coord_t              wall_x;
		coord_t              wall_y;
		logic [CNT_W-1:0]    cells_visited;
		logic [1:0]          status;
	} result_t;

	// x offset of one move, two's complement on COORD_W+1 bits
	function automatic logic [COORD_W:0] step_dx(input logic [1:0] dir);
		logic [COORD_W:0] d;
		case (dir)
			DIR_LEFT:  d = -(COORD_W+1)'(2);
			DIR_RIGHT: d = (COORD_W+1)'(2);
			default:   d = '0;
		endcase
		return d;
	endfunction

	function automatic logic [COORD_W:0] step_dy(input logic [1:0] dir);
		logic [COORD_W:0] d;
		case (dir)
			DIR_UP:   d = -(COORD_W+1)'(2);
			DIR_DOWN: d = (COORD_W+1)'(2);
			default:  d = '0;
		endcase
		return d;
	endfunction

	// odd coordinate strictly inside the grid; top bit set means negative
	function automatic logic cell_inside(input logic [COORD_W:0] x, input logic [COORD_W:0] y,
		input coord_t w, input coord_t h);
		logic [COORD_W:0] xl;
		logic [COORD_W:0] yl;
		xl = {1'b0, w} - (COORD_W+1)'(1);
		yl = {1'b0, h} - (COORD_W+1)'(1);
		return !x[COORD_W] && !y[COORD_W] && (x != '0) && (y != '0)
			&& (x < xl) && (y < yl) && x[0] && y[0];
	endfunction

	// cell address of an odd coordinate pair
	function automatic logic [ADDR_W-1:0] map_index(input logic [COORD_W:0] x,
		input logic [COORD_W:0] y);
		return {y[CELL_W:1], x[CELL_W:1]};
	endfunction

endpackage

`default_nettype wire

// File: design/rwmc_visit_mem.sv
// Visited map: epoch-marked cell memory with a clearing sweep and write bypass flag.
`default_nettype none

module rwmc_visit_mem (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [rwmc_pkg::ADDR_W-1:0]  rd_addr,
	input  wire rwmc_pkg::item_wr_t           item_wr,
	input  wire rwmc_pkg::clr_req_t           clr_req,
	output logic      [rwmc_pkg::EPOCH_W-1:0] rd_data,
	output logic                              rd_hit,
	output logic                              clr_busy
);
	import rwmc_pkg::*;

	logic [EPOCH_W-1:0] mem [MAP_DEPTH];

	logic               clr_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               mark_en_q;
	logic [ADDR_W-1:0]  mark_idx_q;
	logic [EPOCH_W-1:0] mark_epoch_q;

	logic               clr_step;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [EPOCH_W-1:0] wr_data;

	// item writes win; the sweep holds its place while one is written
	assign clr_step = clr_q && !item_wr.en;
	assign wr_en    = item_wr.en || clr_step;

	always_comb begin
		if (item_wr.en) begin
			wr_addr = item_wr.addr;
			wr_data = item_wr.mark;
		end else begin
			wr_addr = clr_addr_q;
			// the sweep keeps the start cell of the begin that caused it
			wr_data = (mark_en_q && (clr_addr_q == mark_idx_q)) ? mark_epoch_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
			// read-before-write: flag a same-cycle write to the read cell
			rd_hit  <= item_wr.en && (item_wr.addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_req.start) begin
			mark_idx_q   <= clr_req.idx;
			mark_epoch_q <= clr_req.epoch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			mark_en_q  <= 1'b0;
		end else if (clr_req.start) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			mark_en_q  <= 1'b1;
		end else if (clr_step) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == '1) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign clr_busy = clr_q;

endmodule

`default_nettype wire

// File: design/rwmc_walk.sv
// First stage: walker state, move decision and visited-map read issue.
`default_nettype none

module rwmc_walk (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          func,
	input  wire rwmc_pkg::coord_t              start_x,
	input  wire rwmc_pkg::coord_t              start_y,
	input  wire logic [1:0]                    dir_first,
	input  wire logic [1:0]                    dir_second,
	input  wire logic [1:0]                    dir_third,
	input  wire logic [1:0]                    dir_fourth,
	input  wire rwmc_pkg::geo_t                geo,
	input  wire logic                          clr_busy,
	input  wire logic                          advance,
	input  wire logic [rwmc_pkg::CNT_W-1:0]    count_next,
	output rwmc_pkg::s1_item_t                 s1,
	output logic                               s1_valid,
	output logic                               rd_en,
	output logic      [rwmc_pkg::ADDR_W-1:0]   rd_addr,
	output rwmc_pkg::clr_req_t                 clr_req
);
	import rwmc_pkg::*;

	coord_t             walker_x_q;
	coord_t             walker_y_q;
	logic               active_q;
	logic [EPOCH_W-1:0] epoch_q;
	s1_item_t           s1_q;
	logic               s1_valid_q;

	logic [3:0][1:0]    dirs;
	logic               accept;
	logic               start_ok;
	logic               finished;
	logic               found;
	logic [COORD_W:0]   tx;
	logic [COORD_W:0]   ty;
	logic [COORD_W:0]   sum_x;
	logic [COORD_W:0]   sum_y;
	logic               wrap;
	logic               active_nxt;
	s1_item_t           nxt;

	assign dirs     = {dir_fourth, dir_third, dir_second, dir_first};
	assign in_ready = !clr_busy && (!s1_valid_q || advance);
	assign accept   = in_valid && in_ready;

	assign start_ok = geo.ok && cell_inside({1'b0, start_x}, {1'b0, start_y},
		geo.width, geo.height);
	assign finished = TOTAL_W'(count_next) >= geo.total;

	// first of the four directions whose target lies inside the grid
	always_comb begin : dir_pick
		logic [COORD_W:0] cx;
		logic [COORD_W:0] cy;
		found = 1'b0;
		tx    = {1'b0, walker_x_q};
		ty    = {1'b0, walker_y_q};
		for (int i = 0; i < 4; i++) begin
			cx = {1'b0, walker_x_q} + step_dx(dirs[i]);
			cy = {1'b0, walker_y_q} + step_dy(dirs[i]);
			if (!found && cell_inside(cx, cy, geo.width, geo.height)) begin
				found = 1'b1;
				tx    = cx;
				ty    = cy;
			end
		end
	end

	assign sum_x = {1'b0, walker_x_q} + tx;
	assign sum_y = {1'b0, walker_y_q} + ty;
	assign wrap  = (func == FUNC_BEGIN) && start_ok && (epoch_q == EPOCH_LAST);

	always_comb begin
		nxt.op     = OP_STAY;
		nxt.cur_x  = walker_x_q;
		nxt.cur_y  = walker_y_q;
		nxt.wall_x = sum_x[COORD_W:1];
		nxt.wall_y = sum_y[COORD_W:1];
		nxt.addr   = map_index(tx, ty);
		nxt.epoch  = epoch_q;
		active_nxt = active_q;
		case (func)
			FUNC_BEGIN: begin
				if (start_ok) begin
					nxt.op     = OP_BEGIN;
					nxt.cur_x  = start_x;
					nxt.cur_y  = start_y;
					nxt.addr   = map_index({1'b0, start_x}, {1'b0, start_y});
					nxt.epoch  = wrap ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
					active_nxt = 1'b1;
				end else begin
					nxt.op     = OP_REJECT;
					active_nxt = 1'b0;
				end
			end
			default: begin
				if (!active_q) begin
					nxt.op = OP_IDLE;
				end else if (!geo.ok) begin
					nxt.op = OP_REJECT;
				end else if (finished) begin
					nxt.op = OP_FIN;
				end else if (found) begin
					nxt.op    = OP_MOVE;
					nxt.cur_x = tx[COORD_W-1:0];
					nxt.cur_y = ty[COORD_W-1:0];
				end else begin
					nxt.op = OP_STAY;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walker_x_q <= '0;
			walker_y_q <= '0;
			active_q   <= 1'b0;
			epoch_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				walker_x_q <= nxt.cur_x;
				walker_y_q <= nxt.cur_y;
				active_q   <= active_nxt;
				epoch_q    <= nxt.epoch;
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= nxt;
		end
	end

	assign s1       = s1_q;
	assign s1_valid = s1_valid_q;
	assign rd_en    = accept;
	assign rd_addr  = nxt.addr;

	assign clr_req.start = accept && wrap;
	assign clr_req.idx   = nxt.addr;
	assign clr_req.epoch = nxt.epoch;

endmodule

`default_nettype wire

// File: design/rwmc_result.sv
// Second stage: visited check, carve, cell count and result register.
`default_nettype none

module rwmc_result (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rwmc_pkg::s1_item_t           s1,
	input  wire logic                         s1_valid,
	input  wire logic [rwmc_pkg::EPOCH_W-1:0] rd_data,
	input  wire logic                         rd_hit,
	input  wire logic [rwmc_pkg::TOTAL_W-1:0] total,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output rwmc_pkg::result_t                 result,
	output logic                              advance,
	output logic      [rwmc_pkg::CNT_W-1:0]   count_next,
	output rwmc_pkg::item_wr_t                item_wr
);
	import rwmc_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	result_t          result_q;

	logic             visited;
	logic             carve;
	logic [CNT_W-1:0] count_res;
	logic [1:0]       status;

	// a stored mark of the current epoch means visited in this maze
	assign visited = rd_hit || (rd_data == s1.epoch);
	assign carve   = (s1.op == OP_MOVE) && !visited;

	always_comb begin
		case (s1.op)
			OP_BEGIN: count_res = CNT_W'(1);
			OP_MOVE:  count_res = (carve && (count_q != CNT_MAX)) ? count_q + CNT_W'(1)
				: count_q;
			default:  count_res = count_q;
		endcase
	end

	always_comb begin
		case (s1.op)
			OP_REJECT: status = ST_REJECT;
			OP_IDLE:   status = ST_IDLE;
			OP_FIN:    status = ST_DONE;
			default:   status = (TOTAL_W'(count_res) >= total) ? ST_DONE : ST_WALK;
		endcase
	end

	assign advance    = s1_valid && (!out_valid_q || out_ready);
	assign count_next = s1_valid ? count_res : count_q;

	assign item_wr.en   = advance && ((s1.op == OP_BEGIN) || carve);
	assign item_wr.addr = s1.addr;
	assign item_wr.mark = s1.epoch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q     <= count_res;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.cur_x         <= s1.cur_x;
			result_q.cur_y         <= s1.cur_y;
			result_q.carved        <= carve;
			result_q.wall_x        <= carve ? s1.wall_x : '0;
			result_q.wall_y        <= carve ? s1.wall_y : '0;
			result_q.cells_visited <= count_res;
			result_q.status        <= status;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

// File: design/random_walk_maze_carver_top.sv
// Top level of the random-walk (Aldous-Broder) maze carver.
`default_nettype none

// Random-walk maze carver. Cells sit at the odd coordinates strictly inside a
// grid of grid_width by grid_height units (odd, 3..65). A begin word (tuser 0)
// places the walker on a start cell and restarts the visited map; a step word
// (tuser 1) carries four directions to try in order, and the walker moves two
// units the first way that stays inside the grid, opening the wall between
// when the target was not yet visited. Every input word gives one result word
// with position, carved wall, visited count and status. Throughput is one word
// per clock while no sweep runs and the master side is ready; a result passes
// the first-stage register, which issues the registered read of the visited
// map, then the result register, where the map is updated. The visited map is
// a 1024-entry memory tagged with an 8-bit epoch, so a begin needs no clearing.
// After reset, and on the 256th accepted begin with a valid start and every
// 255th one after that, a sweep clears the map; s_axis_tready stays low
// during the sweep while configuration writes are still taken. Grid sizes must
// be written through the cfg port while no word is in flight (not enforced).
module random_walk_maze_carver_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input words
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// start_x[6:0], start_y[13:7], dir_first[15:14], dir_second[17:16],
	// dir_third[19:18], dir_fourth[21:20], zero pad [23:22]
	input  wire logic [rwmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// func: 0 begin, 1 step
	input  wire logic                                s_axis_tuser,
	// result words
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// cur_x[6:0], cur_y[13:7], carved[14], wall_x[21:15], wall_y[28:22],
	// cells_visited[39:29], status[41:40], zero pad [47:42]
	output logic      [rwmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// configuration writes: index 0 grid_width, 1 grid_height
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic                                cfg_index,
	input  wire rwmc_pkg::coord_t                    cfg_data
);
	import rwmc_pkg::*;

	coord_t             grid_width_q;
	coord_t             grid_height_q;
	geo_t               geo;

	s1_item_t           s1;
	logic               s1_valid;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [EPOCH_W-1:0] rd_data;
	logic               rd_hit;
	logic               clr_busy;
	clr_req_t           clr_req;
	item_wr_t           item_wr;
	logic               advance;
	logic [CNT_W-1:0]   count_next;
	result_t            result;

	// grid size registers; the port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_LIM;
			grid_height_q <= GRID_LIM;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// geometry check and cell total; (n-1)/2 of an odd n is n>>1
	assign geo.ok = (grid_width_q >= GRID_MIN) && (grid_height_q >= GRID_MIN)
		&& grid_width_q[0] && grid_height_q[0]
		&& (grid_width_q <= GRID_LIM) && (grid_height_q <= GRID_LIM);
	assign geo.width  = grid_width_q;
	assign geo.height = grid_height_q;
	assign geo.total  = TOTAL_W'(grid_width_q[COORD_W-1:1]) *
		TOTAL_W'(grid_height_q[COORD_W-1:1]);

	rwmc_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.func       (s_axis_tuser),
		.start_x    (s_axis_tdata[6:0]),
		.start_y    (s_axis_tdata[13:7]),
		.dir_first  (s_axis_tdata[15:14]),
		.dir_second (s_axis_tdata[17:16]),
		.dir_third  (s_axis_tdata[19:18]),
		.dir_fourth (s_axis_tdata[21:20]),
		.geo        (geo),
		.clr_busy   (clr_busy),
		.advance    (advance),
		.count_next (count_next),
		.s1         (s1),
		.s1_valid   (s1_valid),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.clr_req    (clr_req)
	);

	rwmc_visit_mem u_visit_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.item_wr  (item_wr),
		.clr_req  (clr_req),
		.rd_data  (rd_data),
		.rd_hit   (rd_hit),
		.clr_busy (clr_busy)
	);

	rwmc_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1         (s1),
		.s1_valid   (s1_valid),
		.rd_data    (rd_data),
		.rd_hit     (rd_hit),
		.total      (geo.total),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.result     (result),
		.advance    (advance),
		.count_next (count_next),
		.item_wr    (item_wr)
	);

	assign m_axis_tdata = {
		(OUT_TDATA_W - 42)'(0),
		result.status,
		result.cells_visited,
		result.wall_y,
		result.wall_x,
		result.carved,
		result.cur_y,
		result.cur_x
	};

endmodule

`default_nettype wire
